// ===== rtl/core/svp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// Shared widths, constants, register and sector codes, result beat type.
// ----------------------------------------------------------------------------
package svp_pkg;

  localparam int VW            = 16;
  localparam int CW            = 15;
  localparam int SECW          = 3;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [16:0]   SQRT3_Q16  = 17'd113512;
  localparam logic [15:0]   BUS_RST    = 16'd6144;
  localparam logic [15:0]   PERIOD_RST = 16'd4096;
  localparam logic [CW-1:0] CMP_MAX    = 15'h7fff;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_BUS    = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  localparam logic [SECW-1:0] SEC_NULL = 3'd0;
  localparam logic [SECW-1:0] SEC_S1   = 3'd1;
  localparam logic [SECW-1:0] SEC_S2   = 3'd2;
  localparam logic [SECW-1:0] SEC_S3   = 3'd3;
  localparam logic [SECW-1:0] SEC_S4   = 3'd4;
  localparam logic [SECW-1:0] SEC_S5   = 3'd5;
  localparam logic [SECW-1:0] SEC_S6   = 3'd6;
  localparam logic [SECW-1:0] SEC_FULL = 3'd7;

  typedef struct packed {
    logic [CW-1:0]   ca;
    logic [CW-1:0]   cb;
    logic [CW-1:0]   cc;
    logic [SECW-1:0] code;
    logic            ovm;
  } out_beat_t;

endpackage

// ===== rtl/core/svp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_if
// Valid/ready channels for voltage vectors in and compare beats out.
// ----------------------------------------------------------------------------
interface svp_in_if;
  import svp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] volt_alpha;
  logic signed [VW-1:0] volt_beta;
  modport source (output valid, volt_alpha, volt_beta, input ready);
  modport sink   (input valid, volt_alpha, volt_beta, output ready);
endinterface

interface svp_out_if;
  import svp_pkg::*;
  logic            valid;
  logic            ready;
  logic [CW-1:0]   compare_phase_a;
  logic [CW-1:0]   compare_phase_b;
  logic [CW-1:0]   compare_phase_c;
  logic [SECW-1:0] sector_code;
  logic            overmodulated;
  modport source (output valid, compare_phase_a, compare_phase_b, compare_phase_c,
                  sector_code, overmodulated, input ready);
  modport sink   (input valid, compare_phase_a, compare_phase_b, compare_phase_c,
                  sector_code, overmodulated, output ready);
endinterface

// ===== rtl/core/svp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across lanes. Requires num >> QW < den.
// ----------------------------------------------------------------------------
module svp_div #(
  parameter int NW    = 51,
  parameter int DW    = 25,
  parameter int QW    = 42,
  parameter int LANES = 3,
  parameter int SW    = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SW-1:0]              side_i,
  output logic                       vld_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SW-1:0]              side_o
);

  logic [QW:0]               vld_r;
  logic [DW-1:0]             den_r  [0:QW-1];
  logic [SW-1:0]             side_r [0:QW];
  logic [LANES-1:0][DW-1:0]  rem_r  [0:QW-1];
  logic [LANES-1:0][QW-1:0]  quo_r  [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= den_i;
      side_r[0] <= side_i;
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= DW'(num_i[l][NW-1:QW]);
        quo_r[0][l] <= num_i[l][QW-1:0];
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [LANES-1:0][DW:0]   trial;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][DW-1:0] rem_nxt;
    logic [LANES-1:0][QW-1:0] quo_nxt;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_r[k-1][l], quo_r[k-1][l][QW-1]};
        ge[l]    = (trial[l] >= {1'b0, den_r[k-1]});
        if (ge[l]) begin
          rem_nxt[l] = DW'(trial[l] - {1'b0, den_r[k-1]});
        end else begin
          rem_nxt[l] = trial[l][DW-1:0];
        end
        quo_nxt[l] = {quo_r[k-1][l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
        quo_r[k]  <= quo_nxt;
      end
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign vld_o  = vld_r[QW];
  assign quo_o  = quo_r[QW];
  assign side_o = side_r[QW];

endmodule

// ===== rtl/core/space_vector_pwm_timing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_vector_pwm_timing
// Seven-segment center-aligned SVPWM compare generator.
// ----------------------------------------------------------------------------
// Takes one alpha/beta voltage beat per clock while the output buffer has
// room, and returns the three phase compares, the sector code and the
// overmodulation flag, in order, one beat per clock while the receiver
// keeps up. The datapath holds two bit-per-stage divider pipelines: the
// time-scale divide and the proportional rescale divide. A two-beat output
// buffer lets the block keep taking vectors while one result waits. Write
// bus_voltage and period_counts over APB only while the pipe is empty.
// ----------------------------------------------------------------------------
module space_vector_pwm_timing #(
  parameter int FRAC_BITS = svp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  svp_in_if.sink                      in_chan,
  svp_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [svp_pkg::APB_AW-1:0]  paddr,
  input  logic [svp_pkg::APB_DW-1:0]  pwdata,
  output logic [svp_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import svp_pkg::*;

  localparam int SH  = 17 - FRAC_BITS;
  localparam int PW  = 35;
  localparam int MW  = 52;
  localparam int NW1 = 51;
  localparam int QW1 = NW1 - SH;
  localparam int DW1 = VW + SH;
  localparam int TQ  = VW + FRAC_BITS;
  localparam int KH  = QW1 + 1 - 32;
  localparam int NW2 = TQ + 32;
  localparam int RW  = TQ + 2;

  // config
  logic [VW-1:0] bus_r, per_r;
  logic [VW-1:0] bus_eff;
  logic [TQ-1:0] tsq;
  logic [DW1-1:0] den1;
  logic [NW1-1:0] half1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= BUS_RST;
      per_r <= PERIOD_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_BUS:    bus_r <= pwdata[VW-1:0];
        REG_PERIOD: per_r <= pwdata[VW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BUS:    prdata = APB_DW'(bus_r);
      REG_PERIOD: prdata = APB_DW'(per_r);
      default:    prdata = '0;
    endcase
  end
  assign pready  = 1'b1;
  assign bus_eff = (bus_r == '0) ? VW'(1) : bus_r;
  assign tsq     = {per_r, {FRAC_BITS{1'b0}}};
  assign den1    = {bus_eff, {SH{1'b0}}};
  assign half1   = NW1'({bus_eff, {(SH-1){1'b0}}});

  // flow control
  logic [1:0] cnt_r;
  logic       en;
  assign en            = (cnt_r != 2'd2);
  assign in_chan.ready = en;

  // stage 1: capture
  logic                 s1_v_r;
  logic signed [VW-1:0] s1_al_r, s1_be_r;

  // stage 2: constant products
  logic signed [33:0]   s2_sa_nxt, s2_sb_nxt;
  logic signed [PW-1:0] s2_aext, s2_a3_nxt, s2_bq_nxt;
  logic                 s2_v_r, s2_pa_r;
  logic signed [33:0]   s2_sa_r, s2_sb_r;
  logic signed [PW-1:0] s2_a3_r, s2_bq_r;

  assign s2_sa_nxt = $signed({1'b0, SQRT3_Q16}) * s1_al_r;
  assign s2_sb_nxt = $signed({1'b0, SQRT3_Q16}) * s1_be_r;
  assign s2_aext   = PW'(s1_al_r);
  assign s2_a3_nxt = (s2_aext <<< 17) + (s2_aext <<< 16);
  assign s2_bq_nxt = PW'(s1_be_r) <<< 16;

  // stage 3: sector code and numerators
  logic signed [PW-1:0] s3_sa, s3_sb, s3_db, s3_dc;
  logic signed [PW-1:0] s3_nx_nxt, s3_ny_nxt, s3_nz_nxt;
  logic [SECW-1:0]      s3_code_nxt;
  logic                 s3_v_r;
  logic [SECW-1:0]      s3_code_r;
  logic signed [PW-1:0] s3_nx_r, s3_ny_r, s3_nz_r;

  assign s3_sa       = PW'(s2_sa_r);
  assign s3_sb       = PW'(s2_sb_r);
  assign s3_db       = s3_sa - s2_bq_r;
  assign s3_dc       = -s3_sa - s2_bq_r;
  assign s3_code_nxt = {!s3_dc[PW-1] && (|s3_dc), !s3_db[PW-1] && (|s3_db), s2_pa_r};
  assign s3_nx_nxt   = s3_sb <<< 1;
  assign s3_ny_nxt   = s2_a3_r + s3_sb;
  assign s3_nz_nxt   = s3_sb - s2_a3_r;

  // stage 4: scale by period
  logic signed [MW-1:0] s4_px_r, s4_py_r, s4_pz_r;
  logic                 s4_v_r;
  logic [SECW-1:0]      s4_code_r;
  logic signed [16:0]   ts_s;
  assign ts_s = $signed({1'b0, per_r});

  // stage 5: magnitude plus half divisor
  logic signed [MW-1:0]       s5_ax, s5_ay, s5_az;
  logic                       s5_v_r;
  logic [SECW-1:0]            s5_code_r;
  logic [2:0]                 s5_neg_r;
  logic [2:0][NW1-1:0]        s5_num_r;

  assign s5_ax = s4_px_r[MW-1] ? -s4_px_r : s4_px_r;
  assign s5_ay = s4_py_r[MW-1] ? -s4_py_r : s4_py_r;
  assign s5_az = s4_pz_r[MW-1] ? -s4_pz_r : s4_pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_chan.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_al_r   <= in_chan.volt_alpha;
      s1_be_r   <= in_chan.volt_beta;
      s2_sa_r   <= s2_sa_nxt;
      s2_sb_r   <= s2_sb_nxt;
      s2_a3_r   <= s2_a3_nxt;
      s2_bq_r   <= s2_bq_nxt;
      s2_pa_r   <= !s1_be_r[VW-1] && (|s1_be_r);
      s3_code_r <= s3_code_nxt;
      s3_nx_r   <= s3_nx_nxt;
      s3_ny_r   <= s3_ny_nxt;
      s3_nz_r   <= s3_nz_nxt;
      s4_code_r <= s3_code_r;
      s4_px_r   <= ts_s * s3_nx_r;
      s4_py_r   <= ts_s * s3_ny_r;
      s4_pz_r   <= ts_s * s3_nz_r;
      s5_code_r <= s4_code_r;
      s5_neg_r  <= {s4_pz_r[MW-1], s4_py_r[MW-1], s4_px_r[MW-1]};
      s5_num_r[0] <= s5_ax[NW1-1:0] + half1;
      s5_num_r[1] <= s5_ay[NW1-1:0] + half1;
      s5_num_r[2] <= s5_az[NW1-1:0] + half1;
    end
  end

  // time-scale divide
  logic                d1_v;
  logic [2:0][QW1-1:0] d1_q;
  logic [5:0]          d1_side;

  svp_div #(.NW(NW1), .DW(DW1), .QW(QW1), .LANES(3), .SW(6)) u_div_ts (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(s5_v_r), .num_i(s5_num_r),
    .den_i(den1), .side_i({s5_code_r, s5_neg_r}), .vld_o(d1_v), .quo_o(d1_q),
    .side_o(d1_side)
  );

  // stage 6: restore sign
  logic                  s6_v_r;
  logic [SECW-1:0]       s6_code_r;
  logic signed [QW1:0]   s6_tx_r, s6_ty_r, s6_tz_r;
  logic signed [QW1:0]   s6_qx, s6_qy, s6_qz;

  assign s6_qx = $signed({1'b0, d1_q[0]});
  assign s6_qy = $signed({1'b0, d1_q[1]});
  assign s6_qz = $signed({1'b0, d1_q[2]});

  // stage 7: sector pick, clamp, overmod detect
  logic signed [QW1:0] s7_t1, s7_t2;
  logic [QW1-1:0]      s7_f, s7_s;
  logic [QW1:0]        s7_sum;

  always_comb begin
    case (s6_code_r)
      SEC_S1:  begin s7_t1 = s6_tz_r;  s7_t2 = s6_ty_r;  end
      SEC_S2:  begin s7_t1 = s6_ty_r;  s7_t2 = -s6_tx_r; end
      SEC_S3:  begin s7_t1 = -s6_tz_r; s7_t2 = s6_tx_r;  end
      SEC_S4:  begin s7_t1 = -s6_tx_r; s7_t2 = s6_tz_r;  end
      SEC_S5:  begin s7_t1 = s6_tx_r;  s7_t2 = -s6_ty_r; end
      SEC_S6:  begin s7_t1 = -s6_ty_r; s7_t2 = -s6_tz_r; end
      default: begin s7_t1 = '0;       s7_t2 = '0;       end
    endcase
    s7_f   = s7_t1[QW1] ? '0 : s7_t1[QW1-1:0];
    s7_s   = s7_t2[QW1] ? '0 : s7_t2[QW1-1:0];
    s7_sum = {1'b0, s7_f} + {1'b0, s7_s};
  end

  // halving stages
  logic [KH:0]     hv_r;
  logic [QW1-1:0]  hf_r [0:KH];
  logic [QW1-1:0]  hs_r [0:KH];
  logic [SECW-1:0] hc_r [0:KH];
  logic [KH:0]     ho_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r  <= 1'b0;
      hv_r[0] <= 1'b0;
    end else if (en) begin
      s6_v_r  <= d1_v;
      hv_r[0] <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_code_r <= d1_side[5:3];
      s6_tx_r   <= d1_side[0] ? -s6_qx : s6_qx;
      s6_ty_r   <= d1_side[1] ? -s6_qy : s6_qy;
      s6_tz_r   <= d1_side[2] ? -s6_qz : s6_qz;
      hf_r[0]   <= s7_f;
      hs_r[0]   <= s7_s;
      hc_r[0]   <= s6_code_r;
      ho_r[0]   <= (s7_sum > (QW1+1)'(tsq));
    end
  end

  for (genvar h = 1; h <= KH; h++) begin : g_half
    logic [QW1:0] hsum;
    logic         big;
    assign hsum = {1'b0, hf_r[h-1]} + {1'b0, hs_r[h-1]};
    assign big  = |hsum[QW1:32];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hv_r[h] <= 1'b0;
      end else if (en) begin
        hv_r[h] <= hv_r[h-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hf_r[h] <= big ? (hf_r[h-1] >> 1) : hf_r[h-1];
        hs_r[h] <= big ? (hs_r[h-1] >> 1) : hs_r[h-1];
        hc_r[h] <= hc_r[h-1];
        ho_r[h] <= ho_r[h-1];
      end
    end
  end

  // stage 8: total
  logic            s8_v_r, s8_ovm_r;
  logic [SECW-1:0] s8_code_r;
  logic [31:0]     s8_f_r, s8_s_r, s8_tot_r;

  // stage 9: rescale numerators (den 1 passes times through)
  logic            s9_v_r, s9_ovm_r;
  logic [SECW-1:0] s9_code_r;
  logic [NW2-1:0]  s9_pf, s9_ps;
  logic [1:0][NW2-1:0] s9_num_r;
  logic [31:0]     s9_den_r;

  assign s9_pf = tsq * s8_f_r;
  assign s9_ps = tsq * s8_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= hv_r[KH];
      s9_v_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ovm_r    <= ho_r[KH];
      s8_code_r   <= hc_r[KH];
      s8_f_r      <= hf_r[KH][31:0];
      s8_s_r      <= hs_r[KH][31:0];
      s8_tot_r    <= hf_r[KH][31:0] + hs_r[KH][31:0];
      s9_ovm_r    <= s8_ovm_r;
      s9_code_r   <= s8_code_r;
      s9_num_r[0] <= s8_ovm_r ? s9_pf : NW2'(s8_f_r);
      s9_num_r[1] <= s8_ovm_r ? s9_ps : NW2'(s8_s_r);
      s9_den_r    <= s8_ovm_r ? s8_tot_r : 32'd1;
    end
  end

  // rescale divide
  logic               d2_v;
  logic [1:0][TQ-1:0] d2_q;
  logic [3:0]         d2_side;

  svp_div #(.NW(NW2), .DW(32), .QW(TQ), .LANES(2), .SW(4)) u_div_ovm (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(s9_v_r), .num_i(s9_num_r),
    .den_i(s9_den_r), .side_i({s9_code_r, s9_ovm_r}), .vld_o(d2_v), .quo_o(d2_q),
    .side_o(d2_side)
  );

  // stage 10: segment times
  logic            s10_v_r, s10_ovm_r;
  logic [SECW-1:0] s10_code_r;
  logic [RW-1:0]   s10_ta_r, s10_tb_r, s10_tc_r;
  logic [RW-1:0]   s10_ta, s10_tb;

  assign s10_ta = RW'(tsq) - RW'(d2_q[0]) - RW'(d2_q[1]);
  assign s10_tb = s10_ta + (RW'(d2_q[0]) << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_v_r <= 1'b0;
    end else if (en) begin
      s10_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_code_r <= d2_side[3:1];
      s10_ovm_r  <= d2_side[0];
      s10_ta_r   <= s10_ta;
      s10_tb_r   <= s10_tb;
      s10_tc_r   <= s10_tb + (RW'(d2_q[1]) << 1);
    end
  end

  // stage 11: counts and phase order
  function automatic logic [CW-1:0] to_count(input logic [RW-1:0] x);
    logic [RW:0]             s;
    logic [RW-FRAC_BITS-2:0] c;
    s = {1'b0, x} + ((RW+1)'(1) << (FRAC_BITS + 1));
    c = s[RW:FRAC_BITS+2];
    return (c > (RW-FRAC_BITS-1)'(CMP_MAX)) ? CMP_MAX : c[CW-1:0];
  endfunction

  logic [CW-1:0] ka, kb, kc;
  out_beat_t     beat_nxt;

  assign ka = to_count(s10_ta_r);
  assign kb = to_count(s10_tb_r);
  assign kc = to_count(s10_tc_r);

  always_comb begin
    beat_nxt.code = s10_code_r;
    beat_nxt.ovm  = s10_ovm_r;
    case (s10_code_r)
      SEC_S1:  begin beat_nxt.ca = kb; beat_nxt.cb = ka; beat_nxt.cc = kc; end
      SEC_S2:  begin beat_nxt.ca = ka; beat_nxt.cb = kc; beat_nxt.cc = kb; end
      SEC_S3:  begin beat_nxt.ca = ka; beat_nxt.cb = kb; beat_nxt.cc = kc; end
      SEC_S4:  begin beat_nxt.ca = kc; beat_nxt.cb = kb; beat_nxt.cc = ka; end
      SEC_S5:  begin beat_nxt.ca = kc; beat_nxt.cb = ka; beat_nxt.cc = kb; end
      SEC_S6:  begin beat_nxt.ca = kb; beat_nxt.cb = kc; beat_nxt.cc = ka; end
      default: begin
        beat_nxt.ca  = '0;
        beat_nxt.cb  = '0;
        beat_nxt.cc  = '0;
        beat_nxt.ovm = 1'b0;
      end
    endcase
  end

  // two-beat output buffer
  out_beat_t buf0_r, buf1_r;
  logic      push, pop;

  assign push = s10_v_r && en;
  assign pop  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push && !pop) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt_r == 2'd2) begin
        buf0_r <= buf1_r;
        buf1_r <= beat_nxt;
      end else begin
        buf0_r <= beat_nxt;
      end
    end else if (pop) begin
      buf0_r <= buf1_r;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        buf0_r <= beat_nxt;
      end else begin
        buf1_r <= beat_nxt;
      end
    end
  end

  assign out_chan.valid           = (cnt_r != 2'd0);
  assign out_chan.compare_phase_a = buf0_r.ca;
  assign out_chan.compare_phase_b = buf0_r.cb;
  assign out_chan.compare_phase_c = buf0_r.cc;
  assign out_chan.sector_code     = buf0_r.code;
  assign out_chan.overmodulated   = buf0_r.ovm;

endmodule

// ===== rtl/core/svp_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module svp_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [svp_pkg::CW-1:0]    ca,
  input logic [svp_pkg::CW-1:0]    cb,
  input logic [svp_pkg::CW-1:0]    cc,
  input logic [svp_pkg::SECW-1:0]  code,
  input logic                      ovm
);
  import svp_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({ca, cb, cc, code, ovm}))
    else $error("result beat changed while stalled");

  a_null_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (code == SEC_NULL || code == SEC_FULL)
      |-> ca == '0 && cb == '0 && cc == '0 && !ovm)
    else $error("null sector with nonzero compares");

  a_order_s3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && code == SEC_S3 |-> ca <= cb && cb <= cc)
    else $error("sector three compares out of order");

endmodule

bind space_vector_pwm_timing svp_chk u_svp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .ca        (out_chan.compare_phase_a),
  .cb        (out_chan.compare_phase_b),
  .cc        (out_chan.compare_phase_c),
  .code      (out_chan.sector_code),
  .ovm       (out_chan.overmodulated)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for space_vector_pwm_timing.
// Vectors go in through a valid/ready driver fed from a queue. A bit-exact
// compare predictor computes each expected beat when a vector is taken.
// A monitor checks every output beat in order against those predictions.
// The run goes through several bus/period settings, the extremes among them,
// with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
  import svp_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 3 * FB + 67 + 40;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [VW-1:0] alpha;
    logic signed [VW-1:0] beta;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  svp_in_if  in_chan ();
  svp_out_if out_chan ();

  space_vector_pwm_timing dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  logic [15:0] bus_reg = BUS_RST;
  logic [15:0] period_reg = PERIOD_RST;

  vec_t      vec_q[$];
  out_beat_t compare_q[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_send = 1'b0;
  bit        in_taken = 1'b0;
  int        errors = 0;
  int        beats_in = 0, beats_out = 0, ovm_seen = 0;
  int        sector_seen[8];
  longint    cycles = 0;

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [CW-1:0] to_count(longint unsigned four_t);
    longint unsigned c;
    c = (four_t + (64'd1 << (FB + 1))) >> (FB + 2);
    return (c > CMP_MAX) ? CMP_MAX : c[CW-1:0];
  endfunction

  function automatic out_beat_t predict_compares(vec_t v);
    longint sq, al, be, sa, bq, sb, a3, ts, tsq, bus, den, tx, ty, tz, t1, t2;
    longint unsigned f, s, tot, ta4, tb4, tc4;
    logic [SECW-1:0] code;
    logic ovm;
    out_beat_t r;
    sq = longint'(SQRT3_Q16);
    al = v.alpha;
    be = v.beta;
    sa = sq * al;
    bq = be * 65536;
    sb = sq * be;
    a3 = 3 * 65536 * al;
    ts = longint'(period_reg);
    tsq = ts << FB;
    bus = (bus_reg == 0) ? 1 : longint'(bus_reg);
    den = bus << (17 - FB);
    code = SEC_NULL;
    ovm = 1'b0;
    if (be > 0) code[0] = 1'b1;
    if (sa - bq > 0) code[1] = 1'b1;
    if (-sa - bq > 0) code[2] = 1'b1;
    tx = round_div(ts * (2 * sb), den);
    ty = round_div(ts * (a3 + sb), den);
    tz = round_div(ts * (sb - a3), den);
    case (code)
      SEC_S1: begin t1 = tz;  t2 = ty;  end
      SEC_S2: begin t1 = ty;  t2 = -tx; end
      SEC_S3: begin t1 = -tz; t2 = tx;  end
      SEC_S4: begin t1 = -tx; t2 = tz;  end
      SEC_S5: begin t1 = tx;  t2 = -ty; end
      SEC_S6: begin t1 = -ty; t2 = -tz; end
      default: begin t1 = 0; t2 = 0; end
    endcase
    if (t1 < 0) t1 = 0;
    if (t2 < 0) t2 = 0;
    if (t1 + t2 > tsq) begin
      f = t1;
      s = t2;
      tot = f + s;
      while (tot >= (64'd1 << 32)) begin
        f = f >> 1;
        s = s >> 1;
        tot = f + s;
      end
      if (tot == 0) begin
        f = 0;
        s = 0;
      end else begin
        f = (longint'(tsq) * f) / tot;
        s = (longint'(tsq) * s) / tot;
      end
      t1 = f;
      t2 = s;
      ovm = 1'b1;
    end
    ta4 = tsq - t1 - t2;
    tb4 = ta4 + 2 * t1;
    tc4 = tb4 + 2 * t2;
    case (code)
      SEC_S1: begin r.ca = to_count(tb4); r.cb = to_count(ta4); r.cc = to_count(tc4); end
      SEC_S2: begin r.ca = to_count(ta4); r.cb = to_count(tc4); r.cc = to_count(tb4); end
      SEC_S3: begin r.ca = to_count(ta4); r.cb = to_count(tb4); r.cc = to_count(tc4); end
      SEC_S4: begin r.ca = to_count(tc4); r.cb = to_count(tb4); r.cc = to_count(ta4); end
      SEC_S5: begin r.ca = to_count(tc4); r.cb = to_count(ta4); r.cc = to_count(tb4); end
      SEC_S6: begin r.ca = to_count(tb4); r.cb = to_count(tc4); r.cc = to_count(ta4); end
      default: begin r.ca = '0; r.cb = '0; r.cc = '0; ovm = 1'b0; end
    endcase
    r.code = code;
    r.ovm = ovm;
    return r;
  endfunction

  // input driver and output-ready stall driver
  initial begin
    in_chan.valid = 1'b0;
    in_chan.volt_alpha = '0;
    in_chan.volt_beta = '0;
    out_chan.ready = 1'b0;
  end

  always @(negedge clk) begin
    vec_t nxt;
    if (rst_n && (!in_chan.valid || in_taken)) begin
      if (vec_q.size() != 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
        nxt = vec_q.pop_front();
        in_chan.volt_alpha <= nxt.alpha;
        in_chan.volt_beta <= nxt.beta;
        in_chan.valid <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
    out_chan.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // acceptance and output check
  always @(posedge clk) begin
    out_beat_t want;
    cycles <= cycles + 1;
    in_taken <= in_chan.valid && in_chan.ready;
    if (in_chan.valid && in_chan.ready) begin
      compare_q.push_back(predict_compares({in_chan.volt_alpha, in_chan.volt_beta}));
      beats_in <= beats_in + 1;
    end
    if (out_chan.valid && out_chan.ready) begin
      beats_out <= beats_out + 1;
      if (compare_q.size() == 0) begin
        $error("output beat with no vector pending");
        errors = errors + 1;
      end else begin
        want = compare_q.pop_front();
        sector_seen[want.code] <= sector_seen[want.code] + 1;
        if (want.ovm) ovm_seen <= ovm_seen + 1;
        if (out_chan.compare_phase_a !== want.ca) begin
          $error("compare_phase_a exp %0d got %0d", want.ca, out_chan.compare_phase_a);
          errors = errors + 1;
        end
        if (out_chan.compare_phase_b !== want.cb) begin
          $error("compare_phase_b exp %0d got %0d", want.cb, out_chan.compare_phase_b);
          errors = errors + 1;
        end
        if (out_chan.compare_phase_c !== want.cc) begin
          $error("compare_phase_c exp %0d got %0d", want.cc, out_chan.compare_phase_c);
          errors = errors + 1;
        end
        if (out_chan.sector_code !== want.code) begin
          $error("sector_code exp %0d got %0d", want.code, out_chan.sector_code);
          errors = errors + 1;
        end
        if (out_chan.overmodulated !== want.ovm) begin
          $error("overmodulated exp %0d got %0d", want.ovm, out_chan.overmodulated);
          errors = errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("space_vector_pwm_timing regression: fail");
      $finish;
    end
  end

  task automatic apb_write(input logic reg_idx, input logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_BUS) bus_reg = value;
    else period_reg = value;
  endtask

  task automatic wait_drained();
    while (vec_q.size() != 0 || in_chan.valid || compare_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_vec(input int a, input int b);
    vec_t v;
    v.alpha = VW'(a);
    v.beta = VW'(b);
    vec_q.push_back(v);
  endtask

  task automatic push_random(input int n);
    int k, amp, a, b;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: push_vec(0, 0);
        1, 2: begin
          amp = 1 << $urandom_range(14);
          push_vec($urandom_range(2 * amp) - amp, $urandom_range(2 * amp) - amp);
        end
        3: begin
          // near a sector boundary: beta close to +/- sqrt3 * alpha, or beta = 0
          a = $urandom_range(36000) - 18000;
          b = (a * 1773) / 1024 + $urandom_range(4) - 2;
          if ($urandom_range(1)) b = -b;
          if ($urandom_range(3) == 0) b = 0;
          push_vec(a, b);
        end
        default: push_vec($urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
      endcase
    end
  endtask

  task automatic push_directed();
    push_vec(0, 0);
    push_vec(32767, 0);
    push_vec(-32768, 0);
    push_vec(0, 32767);
    push_vec(0, -32768);
    push_vec(32767, 32767);
    push_vec(-32768, -32768);
    push_vec(32767, -32768);
    push_vec(-32768, 32767);
    push_vec(3464, 2000);
    push_vec(0, 4000);
    push_vec(-3464, 2000);
    push_vec(-3464, -2000);
    push_vec(0, -4000);
    push_vec(3464, -2000);
    push_vec(1000, 1732);
    push_vec(1000, 1733);
    push_vec(-1000, -1732);
    push_vec(-1, 0);
    push_vec(1, 1);
    push_vec(-1, -1);
  endtask

  initial begin
    int p;
    logic [15:0] bus_set[6] = '{16'd6144, 16'd1, 16'd65535, 16'd0, 16'd768, 16'd0};
    logic [15:0] per_set[6] = '{16'd4096, 16'd65535, 16'd1, 16'd0, 16'd65535, 16'd0};
    int idle_set[6] = '{0, 1, 2, 3, 0, 3};
    bus_set[5] = $urandom_range(65535, 1);
    per_set[5] = $urandom_range(65535, 1);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < 6; p++) begin
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      apb_write(REG_BUS, bus_set[p]);
      apb_write(REG_PERIOD, per_set[p]);
      case (idle_set[p])
        1: send_idle_pct = 50;
        2: recv_stall_pct = 50;
        3: begin send_idle_pct = 38; recv_stall_pct = 38; end
        default: ;
      endcase
      push_directed();
      push_random(110);
      if (p == 1) begin
        while (vec_q.size() != 0 || in_chan.valid) @(posedge clk);
        hold_send = 1'b1;
        while (compare_q.size() != 0) @(posedge clk);
        hold_send = 1'b0;
      end
      push_random(110);
    end
    wait_drained();
    $display("vectors in %0d, beats out %0d, overmodulated %0d, six register settings",
             beats_in, beats_out, ovm_seen);
    $display("sector hits 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", sector_seen[0],
             sector_seen[1], sector_seen[2], sector_seen[3], sector_seen[4],
             sector_seen[5], sector_seen[6], sector_seen[7]);
    if (errors == 0) begin
      $display("space_vector_pwm_timing regression: pass");
    end else begin
      $display("space_vector_pwm_timing regression: fail");
    end
    $finish;
  end

endmodule
